>>> src/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared types, codes and helpers of the 3x3 median filter
// Pixel and result types, request codes, register indexes and the small
// compare helpers used by the column cells and the median stage.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 1;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix lo;
        t_pix mid;
        t_pix hi;
    } t_trip;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_ctl;

    typedef struct packed {
        t_pix value;
        logic last_of_frame;
    } t_res;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_trip sort3(input t_trip t);
        t_trip s;
        s.lo  = min3(t.lo, t.mid, t.hi);
        s.mid = med3(t.lo, t.mid, t.hi);
        s.hi  = max3(t.lo, t.mid, t.hi);
        return s;
    endfunction

endpackage

>>> src/mf3_in_if.sv
// ----------------------------------------------------------------------------
// mf3_in_if: input request channel
// Valid/ready channel carrying one pixel or drain request.
// ----------------------------------------------------------------------------
interface mf3_in_if;
    logic          valid;
    logic          ready;
    logic          op;
    mf3_pkg::t_pix pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);
endinterface

>>> src/mf3_out_if.sv
// ----------------------------------------------------------------------------
// mf3_out_if: output result channel
// Valid/ready channel carrying one filtered pixel and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface mf3_out_if;
    logic          valid;
    logic          ready;
    mf3_pkg::t_pix value;
    logic          last_of_frame;

    modport source (output valid, output value, output last_of_frame, input ready);
    modport sink   (input valid, input value, input last_of_frame, output ready);
endinterface

>>> src/mf3_col_cell.sv
// ----------------------------------------------------------------------------
// mf3_col_cell: one window column cell
// Sorts the column handed in on i_col and holds it sorted until the
// next shift.
// ----------------------------------------------------------------------------
module mf3_col_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  mf3_pkg::t_trip i_col,
    output mf3_pkg::t_trip o_col
);

    mf3_pkg::t_trip r_col;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col <= mf3_pkg::sort3(i_col);
        end
    end

    assign o_col = r_col;

endmodule

>>> src/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median: median of three sorted columns
// Two register stages: row extremes and middle, then median of those three.
// ----------------------------------------------------------------------------
module mf3_median (
    input  logic           i_clk,
    input  logic           i_en,
    input  mf3_pkg::t_trip i_col0,
    input  mf3_pkg::t_trip i_col1,
    input  mf3_pkg::t_trip i_col2,
    output mf3_pkg::t_pix  o_med
);

    mf3_pkg::t_pix r_lo;
    mf3_pkg::t_pix r_mid;
    mf3_pkg::t_pix r_hi;
    mf3_pkg::t_pix r_med;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= mf3_pkg::max3(i_col0.lo, i_col1.lo, i_col2.lo);
            r_mid <= mf3_pkg::med3(i_col0.mid, i_col1.mid, i_col2.mid);
            r_hi  <= mf3_pkg::min3(i_col0.hi, i_col1.hi, i_col2.hi);
            r_med <= mf3_pkg::med3(r_lo, r_mid, r_hi);
        end
    end

    assign o_med = r_med;

endmodule

>>> src/median_filter_3x3_core.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_core: streaming 3x3 median filter
// Takes a raster stream of 8-bit grey pixels on i_in and returns on o_out
// the median of each pixel's 3x3 neighborhood, zero on the frame border.
//
// Requests on i_in: op selects a pixel or a drain. A pixel request yields
// the output frame_width+1 raster positions earlier once that many are
// pending; drain requests at a frame boundary push out the remaining
// border zeros one each. last_of_frame marks a frame's final output.
// Configuration: i_cfg_we writes frame_width (index 0) or frame_height
// (index 1); a write restarts the stream. Write only while idle.
// Throughput: one request per cycle while i_in.ready is high. A result
// reaches o_out through the line store read at accept, then the column
// cell, the two median stages and the output register.
// Reset: sizes return to 640 x 480, positions and pending count clear; the
// line stores are not cleared and need no sweep.
// Stall: a two-entry output register/skid pair holds results; i_in.ready
// drops only when both are full.
// ----------------------------------------------------------------------------
module median_filter_3x3_core #(
    parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]      i_cfg_data,
    mf3_in_if.sink                         i_in,
    mf3_out_if.source                      o_out
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    function automatic logic [31:0] clamp_size(input logic [mf3_pkg::CFG_W-1:0] v,
                                               input int unsigned maxv);
        logic [31:0] x;
        x = 32'(v);
        if (x == 32'd0) begin
            return 32'd1;
        end else if (x > maxv) begin
            return maxv;
        end
        return x;
    endfunction

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_pend;
    logic [AW-1:0] r_ocol;
    logic [RW-1:0] r_orow;

    mf3_pkg::t_pix r_mem_up  [MAX_WIDTH];
    mf3_pkg::t_pix r_mem_mid [MAX_WIDTH];
    mf3_pkg::t_pix r_rd_up;
    mf3_pkg::t_pix r_rd_mid;

    logic          r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic          r_s1_isp;
    mf3_pkg::t_pix r_s1_pix;
    logic [AW-1:0] r_s1_addr;
    mf3_pkg::t_ctl r_s1_ctl, r_s2_ctl, r_s3_ctl, r_s4_ctl;

    logic          r_out_valid, r_skid_valid;
    mf3_pkg::t_res r_out, r_skid;

    logic           w_adv, w_accept, w_is_pix, w_pend_full, w_shift;
    logic           w_col_wrap, w_row_wrap, w_ocol_wrap, w_orow_wrap;
    logic           w_push, w_pop;
    logic [WW-1:0]  w_col_p1, w_ocol_p1;
    logic [HW-1:0]  w_row_p1, w_orow_p1;
    mf3_pkg::t_ctl  n_ctl;
    mf3_pkg::t_res  w_push_res;
    mf3_pkg::t_trip w_new_col, w_c0, w_c1, w_c2;
    mf3_pkg::t_pix  w_med;

    assign w_adv     = !r_skid_valid;
    assign w_accept  = i_in.valid && w_adv;
    assign i_in.ready = w_adv;
    assign w_is_pix  = (i_in.op == mf3_pkg::OP_PIXEL);

    assign w_col_p1    = WW'(r_col) + WW'(1);
    assign w_row_p1    = HW'(r_row) + HW'(1);
    assign w_ocol_p1   = WW'(r_ocol) + WW'(1);
    assign w_orow_p1   = HW'(r_orow) + HW'(1);
    assign w_col_wrap  = (w_col_p1 >= r_width);
    assign w_row_wrap  = (w_row_p1 >= r_height);
    assign w_ocol_wrap = (w_ocol_p1 >= r_width);
    assign w_orow_wrap = (w_orow_p1 >= r_height);
    assign w_pend_full = (r_pend >= (PW'(r_width) + PW'(1)));

    always_comb begin
        if (w_is_pix) begin
            n_ctl.emit = w_pend_full;
        end else begin
            n_ctl.emit = (r_pend != '0) && (r_col == '0) && (r_row == '0);
        end
        n_ctl.interior = w_is_pix && (r_orow != '0) && (w_orow_p1 < r_height)
                         && (r_ocol != '0) && (w_ocol_p1 < r_width);
        n_ctl.last     = (w_orow_p1 == r_height) && (w_ocol_p1 == r_width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(clamp_size(mf3_pkg::CFG_W'(mf3_pkg::RESET_WIDTH), MAX_WIDTH));
            r_height <= HW'(clamp_size(mf3_pkg::CFG_W'(mf3_pkg::RESET_HEIGHT), MAX_HEIGHT));
            r_col    <= '0;
            r_row    <= '0;
            r_pend   <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mf3_pkg::REG_FRAME_WIDTH: begin
                    r_width <= WW'(clamp_size(i_cfg_data, MAX_WIDTH));
                end
                mf3_pkg::REG_FRAME_HEIGHT: begin
                    r_height <= HW'(clamp_size(i_cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
            r_ocol <= '0;
            r_orow <= '0;
        end else if (w_accept) begin
            if (w_is_pix) begin
                if (w_col_wrap) begin
                    r_col <= '0;
                    r_row <= w_row_wrap ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
                if (!w_pend_full) begin
                    r_pend <= r_pend + PW'(1);
                end
            end else if (n_ctl.emit) begin
                r_pend <= r_pend - PW'(1);
            end
            if (n_ctl.emit) begin
                if (w_ocol_wrap) begin
                    r_ocol <= '0;
                    r_orow <= w_orow_wrap ? '0 : r_orow + RW'(1);
                end else begin
                    r_ocol <= r_ocol + AW'(1);
                end
            end
        end
    end

    assign w_shift = w_adv && r_s1_valid && r_s1_isp;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_up <= r_mem_up[r_col];
        end
        if (w_shift) begin
            r_mem_up[r_s1_addr] <= r_rd_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_mid <= r_mem_mid[r_col];
        end
        if (w_shift) begin
            r_mem_mid[r_s1_addr] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_isp  <= w_is_pix;
            r_s1_pix  <= i_in.pixel;
            r_s1_addr <= r_col;
            r_s1_ctl  <= n_ctl;
            r_s2_ctl  <= r_s1_ctl;
            r_s3_ctl  <= r_s2_ctl;
            r_s4_ctl  <= r_s3_ctl;
        end
    end

    assign w_new_col.lo  = r_rd_up;
    assign w_new_col.mid = r_rd_mid;
    assign w_new_col.hi  = r_s1_pix;

    mf3_col_cell u_cell2 (.i_clk(i_clk), .i_en(w_shift), .i_col(w_new_col), .o_col(w_c2));
    mf3_col_cell u_cell1 (.i_clk(i_clk), .i_en(w_shift), .i_col(w_c2), .o_col(w_c1));
    mf3_col_cell u_cell0 (.i_clk(i_clk), .i_en(w_shift), .i_col(w_c1), .o_col(w_c0));

    mf3_median u_median (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_col0 (w_c0),
        .i_col1 (w_c1),
        .i_col2 (w_c2),
        .o_med  (w_med)
    );

    assign w_push = w_adv && r_s4_valid && r_s4_ctl.emit;
    assign w_pop  = r_out_valid && o_out.ready;
    assign w_push_res.value         = r_s4_ctl.interior ? w_med : '0;
    assign w_push_res.last_of_frame = r_s4_ctl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= w_push_res;
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid       <= w_push_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.value         = r_out.value;
    assign o_out.last_of_frame = r_out.last_of_frame;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= (PW'(r_width) + PW'(1)))
        else $error("pending count above frame_width+1");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < r_width)
        else $error("input column beyond frame width");

    a_full_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_pix && w_pend_full && !i_cfg_we) |=> (r_s1_valid && r_s1_ctl.emit))
        else $error("pixel at full lag did not produce a result");

endmodule
